[rtl/rau_pkg.sv]
package rau_pkg;

  localparam int unsigned OPERAND_BITS = 16;
  localparam int unsigned IN_W         = 16;
  localparam int unsigned NUM_W        = 32;
  localparam int unsigned DEN_W        = 31;
  // Raw results need 33 bits signed; one spare bit keeps sums exact.
  localparam int unsigned RAW_W        = 34;
  localparam int unsigned MAG_W        = RAW_W - 1;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

endpackage

[rtl/rational_arithmetic_unit.sv]
// Rational arithmetic unit: returns the fraction for a+b, a-b, a*b or a/b, reduced except in the case below.
// Input channel: in_valid/in_stall with in_command and the four 16-bit operands.
// A transaction is taken when in_valid is high and in_stall is low. in_stall is
// high from acceptance until the result has been taken, so one item is in the
// block at a time.
// Output channel: out_valid/out_stall with out_res_num and out_res_den.
// Sequence: three products on the shared 16x16 multiplier, the S_PREP and S_RED
// set-up states, a binary gcd loop of compare/subtract/shift steps, and two
// 33-step restoring divisions that share one subtractor. When both raw parts
// are at most zero the raw values are returned unreduced, without the gcd loop
// and the divisions.
// When the receiver stalls, the result is held steady on the output ports
// and no new transaction is taken until it has been accepted.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_valid.
module rational_arithmetic_unit #(
  parameter int unsigned OPERAND_BITS = rau_pkg::OPERAND_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        in_command,
  input  logic signed [rau_pkg::IN_W-1:0]   in_a_num,
  input  logic signed [rau_pkg::IN_W-1:0]   in_a_den,
  input  logic signed [rau_pkg::IN_W-1:0]   in_b_num,
  input  logic signed [rau_pkg::IN_W-1:0]   in_b_den,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [rau_pkg::NUM_W-1:0]  out_res_num,
  output logic signed [rau_pkg::DEN_W-1:0]  out_res_den
);

  localparam int unsigned IW = rau_pkg::IN_W;
  localparam int unsigned RW = rau_pkg::RAW_W;
  localparam int unsigned MW = rau_pkg::MAG_W;
  localparam int unsigned PW = 2 * IW;
  localparam int unsigned KW = $clog2(MW + 1);
  // Clamp limit in IW+1 bits; widths above IW leave the operands untouched.
  localparam logic signed [IW:0] LIM = (OPERAND_BITS > IW) ?
    (IW+1)'(1 << (IW - 1)) : (IW+1)'((1 << (OPERAND_BITS - 1)) - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_PREP, S_RED, S_GCD, S_DIVN, S_DIVD, S_OUT
  } state_t;

  state_t               state_r, state_nxt;
  rau_pkg::cmd_t        cmd_r, cmd_nxt;
  logic signed [IW-1:0] an_r, ad_r, bn_r, bd_r, an_nxt, ad_nxt, bn_nxt, bd_nxt;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p0_nxt, p1_nxt, p2_nxt;
  logic signed [RW-1:0] num_r, den_r, num_nxt, den_nxt;
  logic [MW-1:0]        x_r, y_r, g_r, quo_r, rem_r;
  logic [MW-1:0]        x_nxt, y_nxt, g_nxt, quo_nxt, rem_nxt;
  logic [KW-1:0]        k_r, k_nxt, cnt_r, cnt_nxt;
  logic signed [rau_pkg::NUM_W-1:0] rnum_r, rnum_nxt;
  logic signed [rau_pkg::DEN_W-1:0] rden_r, rden_nxt;

  logic signed [IW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;
  logic [MW-1:0]        num_mag, den_mag, diff_xy, diff_yx;
  logic [MW:0]          div_sh, div_sub;
  logic [MW-1:0]        div_rem, div_quo;
  logic signed [RW-1:0] div_signed;
  logic                 addsub;

  function automatic logic signed [IW-1:0] narrow(input logic signed [IW-1:0] v);
    logic signed [IW:0] w;
    w = (IW+1)'(v);
    if (w > LIM) begin
      w = LIM;
    end else if (w < -LIM) begin
      w = -LIM;
    end
    return w[IW-1:0];
  endfunction

  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = (state_r == S_OUT);
  assign out_res_num = rnum_r;
  assign out_res_den = rden_r;

  assign addsub  = (cmd_r == rau_pkg::CMD_ADD) || (cmd_r == rau_pkg::CMD_SUB);
  assign mul_p   = mul_a * mul_b;
  assign num_mag = num_r[RW-1] ? MW'(-num_r) : MW'(num_r);
  assign den_mag = den_r[RW-1] ? MW'(-den_r) : MW'(den_r);
  assign diff_xy = x_r - y_r;
  assign diff_yx = y_r - x_r;

  // One restoring division step, shared by numerator and denominator.
  assign div_sh     = {rem_r, quo_r[MW-1]};
  assign div_sub    = div_sh - {1'b0, g_r};
  assign div_rem    = div_sub[MW] ? div_sh[MW-1:0] : div_sub[MW-1:0];
  assign div_quo    = {quo_r[MW-2:0], ~div_sub[MW]};
  assign div_signed = (state_r == S_DIVN ? num_r[RW-1] : den_r[RW-1]) ?
                      -RW'(div_quo) : RW'(div_quo);

  always_comb begin
    mul_a = an_r;
    mul_b = bd_r;
    case (state_r)
      S_MUL0: begin
        mul_a = an_r;
        mul_b = (cmd_r == rau_pkg::CMD_MUL) ? bn_r : bd_r;
      end
      S_MUL1: begin
        mul_a = addsub ? bn_r : ad_r;
        mul_b = (cmd_r == rau_pkg::CMD_DIV) ? bn_r :
                (cmd_r == rau_pkg::CMD_MUL) ? bd_r : ad_r;
      end
      default: begin
        mul_a = ad_r;
        mul_b = bd_r;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    an_nxt = an_r; ad_nxt = ad_r; bn_nxt = bn_r; bd_nxt = bd_r;
    p0_nxt = p0_r; p1_nxt = p1_r; p2_nxt = p2_r;
    num_nxt = num_r; den_nxt = den_r;
    x_nxt = x_r; y_nxt = y_r; g_nxt = g_r; k_nxt = k_r;
    quo_nxt = quo_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    rnum_nxt = rnum_r; rden_nxt = rden_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = rau_pkg::cmd_t'(in_command);
          an_nxt    = narrow(in_a_num);
          ad_nxt    = narrow(in_a_den);
          bn_nxt    = narrow(in_b_num);
          bd_nxt    = narrow(in_b_den);
          state_nxt = S_MUL0;
        end
      end
      S_MUL0: begin
        p0_nxt    = mul_p;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        p1_nxt    = mul_p;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        p2_nxt    = mul_p;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        if (addsub && (ad_r == bd_r)) begin
          num_nxt = (cmd_r == rau_pkg::CMD_ADD) ? RW'(an_r) + RW'(bn_r)
                                                : RW'(an_r) - RW'(bn_r);
          den_nxt = RW'(ad_r);
        end else if (addsub) begin
          num_nxt = (cmd_r == rau_pkg::CMD_ADD) ? RW'(p0_r) + RW'(p1_r)
                                                : RW'(p0_r) - RW'(p1_r);
          den_nxt = RW'(p2_r);
        end else begin
          num_nxt = RW'(p0_r);
          den_nxt = RW'(p1_r);
        end
        state_nxt = S_RED;
      end
      S_RED: begin
        x_nxt = num_mag;
        y_nxt = den_mag;
        k_nxt = '0;
        if ((num_r <= 0) && (den_r <= 0)) begin
          // Both raw parts at most zero: the raw values are passed out unreduced.
          rnum_nxt  = num_r[rau_pkg::NUM_W-1:0];
          rden_nxt  = den_r[rau_pkg::DEN_W-1:0];
          state_nxt = S_OUT;
        end else if (num_mag == '0) begin
          g_nxt     = den_mag;
          state_nxt = S_DIVN;
        end else if (den_mag == '0) begin
          g_nxt     = num_mag;
          state_nxt = S_DIVN;
        end else begin
          state_nxt = S_GCD;
        end
        quo_nxt = num_mag;
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      S_GCD: begin
        if (x_r == y_r) begin
          g_nxt     = x_r << k_r;
          state_nxt = S_DIVN;
        end else if (!x_r[0] && !y_r[0]) begin
          x_nxt = x_r >> 1;
          y_nxt = y_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (x_r > y_r) begin
          x_nxt = diff_xy;
        end else begin
          y_nxt = diff_yx;
        end
      end
      S_DIVN: begin
        rem_nxt = div_rem;
        quo_nxt = div_quo;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == KW'(MW - 1)) begin
          rnum_nxt  = div_signed[rau_pkg::NUM_W-1:0];
          quo_nxt   = den_mag;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIVD;
        end
      end
      S_DIVD: begin
        rem_nxt = div_rem;
        quo_nxt = div_quo;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == KW'(MW - 1)) begin
          rden_nxt  = div_signed[rau_pkg::DEN_W-1:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cmd_r <= cmd_nxt;
    an_r <= an_nxt; ad_r <= ad_nxt; bn_r <= bn_nxt; bd_r <= bd_nxt;
    p0_r <= p0_nxt; p1_r <= p1_nxt; p2_r <= p2_nxt;
    num_r <= num_nxt; den_r <= den_nxt;
    x_r <= x_nxt; y_r <= y_nxt; g_r <= g_nxt; k_r <= k_nxt;
    quo_r <= quo_nxt; rem_r <= rem_nxt; cnt_r <= cnt_nxt;
    rnum_r <= rnum_nxt; rden_r <= rden_nxt;
  end

endmodule
